### src/tpe_pkg.sv
`default_nettype none

package tpe_pkg;

    // Field widths of the sample stream, the results and the registers.
    localparam int SAMPLE_W    = 12;
    localparam int FILT_W      = 28;
    localparam int GAIN_W      = 16;
    localparam int HALF_W      = 11;
    localparam int FULL_W      = 12;
    localparam int TOL_W       = 8;
    localparam int IDX_BITS    = 12;
    localparam int PHASE_W     = 12;
    localparam int STATUS_W    = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Defaults of the top-level parameters.
    localparam int MAX_EXTREMA_DEF      = 20;
    localparam int FRAME_LENGTH_MAX_DEF = 4096;

    // Filter window, event queue and remainder unit sizes.
    localparam int WIN_DEPTH = 5;
    localparam int EVQ_DEPTH = 4;
    localparam int DIV_W     = 13;
    localparam int DIV_STEPS = 13;

    // Register reset values.
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(655);
    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(123);
    localparam logic [FULL_W-1:0] FULL_RESET = FULL_W'(246);
    localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(20);

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_GAIN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_PERIOD = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPACING_TOL = 2'd3;

    // Status codes of a result.
    localparam logic [STATUS_W-1:0] ST_VALID    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_PAIR  = 2'd3;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [HALF_W-1:0] half;
        logic [FULL_W-1:0] full;
        logic [TOL_W-1:0]  tol;
    } cfg_t;

    // One entry of the event queue: an extremum, a frame end, or both.
    typedef struct packed {
        logic                is_ext;
        logic                is_peak;
        logic [IDX_BITS-1:0] idx;
        logic                last;
    } evt_t;

endpackage

`default_nettype wire

### src/tpe_front.sv
`default_nettype none

module tpe_front
    import tpe_pkg::*;
#(
    parameter int FRAME_LENGTH_MAX = FRAME_LENGTH_MAX_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [GAIN_W-1:0]   gain,
    input  wire logic                push,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic                frame_end,
    output logic                     full,
    input  wire logic                evq_ready,
    output logic                     evq_push,
    output evt_t                     evq_data
);

    localparam int IDX_W = $clog2(FRAME_LENGTH_MAX + 1);

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [FILT_W-1:0] win_reg [WIN_DEPTH];

    logic                s2_valid_reg;
    logic                s2_test_reg;
    logic [IDX_BITS-1:0] s2_n_reg;
    logic                s2_last_reg;

    logic accept;
    logic in_range;
    logic s2_stall;
    logic s2_need;

    logic signed [FILT_W:0]   diff;
    logic signed [45:0]       prod;
    logic signed [45:0]       rounded;
    logic signed [29:0]       step;
    logic signed [29:0]       ysum;
    logic [FILT_W-1:0]        y;

    logic peak;
    logic trough;
    logic ext;

    // Stage two holds the sample under test until its event has a place in the queue.
    assign s2_need  = (s2_test_reg && (peak || trough)) || s2_last_reg;
    assign s2_stall = s2_valid_reg && s2_need && !evq_ready;
    assign full     = s2_stall;
    assign accept   = push && !full;
    assign in_range = idx_reg < IDX_W'(FRAME_LENGTH_MAX);

    // One-pole filter, rewritten as y + g*(x - y) so that one multiplier suffices.
    always_comb
    begin
        diff    = $signed({1'b0, sample, 16'b0}) - $signed({1'b0, win_reg[WIN_DEPTH-1]});
        prod    = 46'(diff * $signed({1'b0, gain}));
        rounded = prod + 46'sd32768;
        step    = rounded[45:16];
        ysum    = $signed({2'b0, win_reg[WIN_DEPTH-1]}) + step;
        if (idx_reg == '0)
        begin
            y = {sample, 16'b0};
        end
        else
        begin
            y = ysum[FILT_W-1:0];
        end
    end

    // Sample counter: stops at the frame limit and restarts after a frame end.
    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                idx_next = '0;
            end
            else if (in_range)
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (!s2_stall)
            begin
                s2_valid_reg <= accept;
            end
        end
    end

    // Filter window shifts by one place for every sample inside the frame limit.
    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            for (int k = 0; k < WIN_DEPTH - 1; k++)
            begin
                win_reg[k] <= win_reg[k+1];
            end
            win_reg[WIN_DEPTH-1] <= y;
        end
    end

    // Stage two payload: the window center sits two places behind the newest sample.
    always_ff @(posedge clk)
    begin
        if (!s2_stall)
        begin
            s2_test_reg <= in_range && (idx_reg >= IDX_W'(4));
            s2_n_reg    <= IDX_BITS'(idx_reg - IDX_W'(2));
            s2_last_reg <= frame_end;
        end
    end

    // Peak and trough tests on the registered window.
    always_comb
    begin
        peak   = (win_reg[2] >  win_reg[0]) && (win_reg[2] >= win_reg[1]) &&
                 (win_reg[2] >  win_reg[4]) && (win_reg[2] >= win_reg[3]);
        trough = (win_reg[2] <  win_reg[0]) && (win_reg[2] <= win_reg[1]) &&
                 (win_reg[2] <  win_reg[4]) && (win_reg[2] <= win_reg[3]);
        ext    = s2_test_reg && (peak || trough);
    end

    assign evq_push         = s2_valid_reg && s2_need && evq_ready;
    assign evq_data.is_ext  = ext;
    assign evq_data.is_peak = peak;
    assign evq_data.idx     = s2_n_reg;
    assign evq_data.last    = s2_last_reg;

endmodule

`default_nettype wire

### src/tpe_evq.sv
`default_nettype none

module tpe_evq
    import tpe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire evt_t wr_data,
    output logic      ready,
    input  wire logic rd_en,
    output logic      valid,
    output evt_t      rd_data
);

    localparam int PTR_W = $clog2(EVQ_DEPTH);
    localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

    evt_t             mem_reg [EVQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign ready   = count_reg != CNT_W'(EVQ_DEPTH);
    assign valid   = count_reg != '0;
    assign do_wr   = wr_en && ready;
    assign do_rd   = rd_en && valid;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Circular buffer pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### src/tpe_phase_div.sv
`default_nettype none

module tpe_phase_div
    import tpe_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] modulus,
    output logic                  busy,
    output logic [PHASE_W-1:0]    phase
);

    localparam int STEP_W  = $clog2(DIV_STEPS);
    localparam int TRIAL_W = DIV_W + DIV_STEPS - 1;

    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   mod_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic [TRIAL_W-1:0] trial;
    logic               fits;
    logic [DIV_W-1:0]   rem_plus;

    // Restoring remainder: one shifted modulus is tried per cycle, highest first.
    assign trial    = TRIAL_W'(mod_reg) << step_reg;
    assign fits     = TRIAL_W'(rem_reg) >= trial;
    assign busy     = busy_reg;
    assign rem_plus = rem_reg + DIV_W'(1);
    assign phase    = rem_plus[PHASE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            mod_reg <= modulus;
        end
        else if (busy_reg && fits)
        begin
            rem_reg <= rem_reg - trial[DIV_W-1:0];
        end
    end

endmodule

`default_nettype wire

### src/tpe_back.sv
`default_nettype none

module tpe_back
    import tpe_pkg::*;
#(
    parameter int MAX_EXTREMA = MAX_EXTREMA_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               evq_valid,
    input  wire evt_t               evq_data,
    output logic                    evq_pop,
    input  wire logic               pop,
    output logic                    empty,
    output logic [PHASE_W-1:0]      phase,
    output logic [STATUS_W-1:0]     status
);

    localparam int CNT_W = $clog2(MAX_EXTREMA + 1);

    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [IDX_BITS-1:0] prev_idx_reg;
    logic [IDX_BITS-1:0] prev_idx_next;
    logic                prev_peak_reg;
    logic                prev_peak_next;
    logic                pair_reg;
    logic                pair_next;
    logic                end_pend_reg;
    logic                end_pend_next;

    logic                out_valid_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [STATUS_W-1:0] status_reg;

    logic                take;
    logic                note;
    logic signed [13:0]  dev;
    logic [13:0]         dev_mag;
    logic                pair_hit;
    logic [DIV_W-1:0]    t_val;
    logic [DIV_W-1:0]    modulus;
    logic                div_busy;
    logic [PHASE_W-1:0]  div_phase;
    logic                out_free;
    logic                final_now;
    logic                emit;
    logic [STATUS_W-1:0] status_new;

    // An event is taken unless a frame end is still waiting to be reported.
    assign take    = evq_valid && !end_pend_reg;
    assign evq_pop = take;
    assign note    = take && evq_data.is_ext && (cnt_reg < CNT_W'(MAX_EXTREMA));

    // Spacing against the half period, and the start point of the phase.
    always_comb
    begin
        dev = $signed({2'b0, evq_data.idx}) - $signed({2'b0, prev_idx_reg}) -
              $signed({3'b0, cfg.half});
        if (dev[13])
        begin
            dev_mag = 14'(-dev);
        end
        else
        begin
            dev_mag = 14'(dev);
        end
        pair_hit = note && (cnt_reg != '0) && !pair_reg &&
                   (prev_peak_reg != evq_data.is_peak) && (dev_mag < 14'(cfg.tol));
        t_val    = DIV_W'(prev_idx_reg) + (prev_peak_reg ? '0 : DIV_W'(cfg.half));
        modulus  = (cfg.full == '0) ? (DIV_W'(1) << FULL_W) : DIV_W'(cfg.full);
    end

    tpe_phase_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pair_hit),
        .dividend (t_val - DIV_W'(1)),
        .modulus  (modulus),
        .busy     (div_busy),
        .phase    (div_phase)
    );

    // Extremum bookkeeping after the event of this cycle.
    always_comb
    begin
        cnt_next       = cnt_reg;
        prev_idx_next  = prev_idx_reg;
        prev_peak_next = prev_peak_reg;
        pair_next      = pair_reg || pair_hit;
        if (note)
        begin
            cnt_next       = cnt_reg + CNT_W'(1);
            prev_idx_next  = evq_data.idx;
            prev_peak_next = evq_data.is_peak;
        end
    end

    // Frame end is reported at once unless the divider or a held result stalls it.
    assign out_free  = !out_valid_reg || pop;
    assign final_now = take && evq_data.last && !div_busy && !pair_hit && out_free;
    assign emit      = final_now || (end_pend_reg && !div_busy && out_free);

    always_comb
    begin
        end_pend_next = end_pend_reg;
        if (emit)
        begin
            end_pend_next = 1'b0;
        end
        else if (take && evq_data.last)
        begin
            end_pend_next = 1'b1;
        end
    end

    always_comb
    begin
        priority if (cnt_next >= CNT_W'(MAX_EXTREMA))
        begin
            status_new = ST_TOO_MANY;
        end
        else if (cnt_next < CNT_W'(2))
        begin
            status_new = ST_FEW;
        end
        else if (!pair_next)
        begin
            status_new = ST_NO_PAIR;
        end
        else
        begin
            status_new = ST_VALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            prev_idx_reg  <= '0;
            prev_peak_reg <= 1'b0;
            pair_reg      <= 1'b0;
            end_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            end_pend_reg <= end_pend_next;
            if (emit)
            begin
                cnt_reg       <= '0;
                prev_idx_reg  <= '0;
                prev_peak_reg <= 1'b0;
                pair_reg      <= 1'b0;
            end
            else
            begin
                cnt_reg       <= cnt_next;
                prev_idx_reg  <= prev_idx_next;
                prev_peak_reg <= prev_peak_next;
                pair_reg      <= pair_next;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= status_new;
            phase_reg  <= (status_new == ST_VALID) ? div_phase : '0;
        end
    end

    assign empty  = !out_valid_reg;
    assign phase  = phase_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

### src/tone_phase_extractor_core.sv
`default_nettype none

// Tone phase extractor for one converter channel. Samples enter one per clock
// through push/full while full is low; the sample carrying frame_end closes
// the frame and yields one result (phase, status) on the empty/pop side after
// the window stage, the event queue and the result register. The front end
// runs the one-pole low-pass filter and the five-sample peak/trough window and
// takes one sample every cycle while full is low; the back end tracks extrema.
// Once the matching peak/trough pair is found, its phase is reduced modulo
// full_period by a remainder unit; a frame end that arrives while it is busy
// waits for it. Events behind a waiting frame end collect in the four-entry
// event queue, and full rises only once that queue is full and the window
// stage holds one more event. A pending result that is not popped holds the
// frame end behind it in the same way. Configuration is written through
// cfg_write/cfg_index/cfg_data and must change only while the block is idle.
module tone_phase_extractor_core
    import tpe_pkg::*;
#(
    parameter int MAX_EXTREMA      = MAX_EXTREMA_DEF,
    parameter int FRAME_LENGTH_MAX = FRAME_LENGTH_MAX_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [SAMPLE_W-1:0]    sample,
    input  wire logic                   frame_end,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [PHASE_W-1:0]          phase,
    output logic [STATUS_W-1:0]         status
);

    cfg_t cfg_reg;
    logic evq_push;
    logic evq_ready;
    evt_t evq_wdata;
    logic evq_valid;
    logic evq_pop;
    evt_t evq_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain <= GAIN_RESET;
            cfg_reg.half <= HALF_RESET;
            cfg_reg.full <= FULL_RESET;
            cfg_reg.tol  <= TOL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FILTER_GAIN: cfg_reg.gain <= cfg_data[GAIN_W-1:0];
                REG_HALF_PERIOD: cfg_reg.half <= cfg_data[HALF_W-1:0];
                REG_FULL_PERIOD: cfg_reg.full <= cfg_data[FULL_W-1:0];
                REG_SPACING_TOL: cfg_reg.tol  <= cfg_data[TOL_W-1:0];
                default:         cfg_reg      <= cfg_reg;
            endcase
        end
    end

    tpe_front #(
        .FRAME_LENGTH_MAX (FRAME_LENGTH_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (cfg_reg.gain),
        .push      (push),
        .sample    (sample),
        .frame_end (frame_end),
        .full      (full),
        .evq_ready (evq_ready),
        .evq_push  (evq_push),
        .evq_data  (evq_wdata)
    );

    tpe_evq u_evq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (evq_push),
        .wr_data (evq_wdata),
        .ready   (evq_ready),
        .rd_en   (evq_pop),
        .valid   (evq_valid),
        .rd_data (evq_rdata)
    );

    tpe_back #(
        .MAX_EXTREMA (MAX_EXTREMA)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .evq_valid (evq_valid),
        .evq_data  (evq_rdata),
        .evq_pop   (evq_pop),
        .pop       (pop),
        .empty     (empty),
        .phase     (phase),
        .status    (status)
    );

`ifndef SYNTHESIS
    // A valid result carries a phase in one to full_period.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_VALID && cfg_reg.full != '0) |->
            (phase != '0 && phase <= cfg_reg.full))
        else $error("phase outside one to full_period on a valid result");

    // Any other status reports a zero phase.
    a_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_VALID) |-> (phase == '0))
        else $error("nonzero phase on a result that is not valid");

    // The front end only refuses samples while the event queue is full.
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !evq_ready)
        else $error("full raised while the event queue has room");
`endif

endmodule

`default_nettype wire
